// File: design/swnl_pkg.sv
`timescale 1ns / 1ps
package swnl_pkg;
  localparam int NODES = 1024;
  localparam int MAX_WORKERS = 8;
  localparam int NW = $clog2(NODES);
  localparam int CW = NW + 1;
  localparam int WW = $clog2(MAX_WORKERS);
  localparam int MW = MAX_WORKERS;

  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_INIT = 3'd2;
  localparam logic [2:0] MODE_SET = 3'd3;
  localparam logic [2:0] MODE_TRIM = 3'd4;
  localparam logic [2:0] MODE_STATUS = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic REG_WORKERS = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_W1, S_TRD, S_TW, S_DONE
  } state_t;
endpackage

// File: design/sliding_window_node_list.sv
`timescale 1ns / 1ps
// append, remove and set marker pass through the read, write and done states;
// init, status and rejected transactions pass through the read and done states, then idle
// trim: an empty list goes to done; else each head node is read, then released or trim stops
// one transaction at a time; out_ready stalls hold the result and the next acceptance
// reset: synchronous active-low rst_n clears counters, pointers, markers and worker count;
// node memories are not cleared, every entry is written at allocation before it is read
module sliding_window_node_list
  import swnl_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_mode,
  input  logic [9:0]    in_node_index,
  input  logic [2:0]    in_worker_id,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [9:0]    out_result_node,
  output logic [9:0]    out_head_node,
  output logic [9:0]    out_tail_node,
  output logic [10:0]   out_live_count,
  output logic [10:0]   out_free_count,
  output logic          out_is_full,
  output logic [9:0]    out_marker_node,
  output logic [10:0]   out_trimmed,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  state_t state_r, state_nxt;
  logic [3:0] wcnt_r;
  logic [10:0] wlim_r;
  logic [NW-1:0] head_r, tail_r, fhead_r;
  logic [CW-1:0] clive_r, cfree_r, fresh_r, trim_r;
  logic [NW-1:0] marker_r [MW];
  logic [2:0] mode_r;
  logic [NW-1:0] node_r, res_r, n_r, p_r, q_r;
  logic [2:0] wid_r;
  logic [1:0] st_r;

  // memories
  logic nx_we, pv_we, um_we, lv_we;
  logic [NW-1:0] nx_wa, nx_wd, nx_ra, nx_rd, pv_wa, pv_wd, pv_ra, pv_rd, um_wa, um_ra;
  logic [NW-1:0] lv_wa, lv_ra;
  logic [MW-1:0] um_wd, um_rd;
  logic [0:0] lv_wd, lv_rd;
  swnl_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next (.clk, .we(nx_we), .waddr(nx_wa),
    .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  swnl_ram #(.WIDTH(NW), .DEPTH(NODES)) u_prev (.clk, .we(pv_we), .waddr(pv_wa),
    .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
  swnl_ram #(.WIDTH(MW), .DEPTH(NODES)) u_mask (.clk, .we(um_we), .waddr(um_wa),
    .wdata(um_wd), .raddr(um_ra), .rdata(um_rd));
  swnl_ram #(.WIDTH(1), .DEPTH(NODES)) u_live (.clk, .we(lv_we), .waddr(lv_wa),
    .wdata(lv_wd), .raddr(lv_ra), .rdata(lv_rd));

  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  always_comb begin
    case (cfg_paddr[2])
      REG_WORKERS: cfg_prdata = {28'd0, wcnt_r};
      REG_LIMIT: cfg_prdata = {21'd0, wlim_r};
      default: cfg_prdata = '0;
    endcase
  end

  logic node_ok;
  logic [MW-1:0] init_bits;
  assign node_ok = {1'b0, node_r} < fresh_r;
  always_comb begin
    int w;
    w = (int'(wcnt_r) > MAX_WORKERS) ? MAX_WORKERS : int'(wcnt_r);
    if (w == 0) w = 1;
    for (int i = 0; i < MW; i++) init_bits[i] = (i < w);
  end

  logic app_free, app_fresh, app_ok, rm_ok, rm_mid;
  logic [NW-1:0] app_n, old_mk;
  logic [MW-1:0] set_bit;
  assign app_free = (cfree_r != '0);
  assign app_fresh = (fresh_r < CW'(NODES));
  assign app_ok = app_free | app_fresh;
  assign app_n = app_free ? fhead_r : fresh_r[NW-1:0];
  assign rm_ok = node_ok & lv_rd[0];
  assign rm_mid = (clive_r != CW'(1)) && (node_r != head_r) && (node_r != tail_r);
  assign set_bit = MW'(1) << wid_r;
  assign old_mk = marker_r[wid_r];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RD1;
      S_RD1: begin
        case (mode_r)
          MODE_APPEND: state_nxt = app_ok ? S_W1 : S_DONE;
          MODE_REMOVE: state_nxt = rm_ok ? S_W1 : S_DONE;
          MODE_SET: state_nxt = node_ok ? S_W1 : S_DONE;
          MODE_TRIM: state_nxt = (clive_r == '0) ? S_DONE : S_TRD;
          default: state_nxt = S_DONE;
        endcase
      end
      S_W1: state_nxt = S_DONE;
      S_TRD: state_nxt = S_TW;
      S_TW: state_nxt = (um_rd == '0 && clive_r != CW'(1)) ? S_TRD : S_DONE;
      S_DONE: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    nx_we = 1'b0; nx_wa = node_r; nx_wd = '0;
    pv_we = 1'b0; pv_wa = node_r; pv_wd = '0;
    um_we = 1'b0; um_wa = node_r; um_wd = '0;
    lv_we = 1'b0; lv_wa = node_r; lv_wd = 1'b0;
    nx_ra = node_r; pv_ra = node_r; um_ra = node_r; lv_ra = node_r;
    case (state_r)
      S_IDLE: begin
        nx_ra = (in_mode == MODE_APPEND) ? fhead_r : in_node_index;
        pv_ra = in_node_index;
        lv_ra = in_node_index;
        um_ra = (in_mode == MODE_SET) ? marker_r[in_worker_id] : in_node_index;
      end
      S_RD1: begin
        case (mode_r)
          MODE_APPEND: if (app_ok) begin
            nx_we = 1'b1; nx_wa = app_n; nx_wd = '0;
            um_we = 1'b1; um_wa = app_n; um_wd = '0;
            lv_we = 1'b1; lv_wa = app_n; lv_wd = 1'b1;
            pv_we = 1'b1; pv_wa = app_n; pv_wd = (clive_r == '0) ? '0 : tail_r;
          end
          MODE_REMOVE: if (rm_ok && rm_mid) begin
            nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
            pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
          end
          MODE_INIT: if (node_ok) begin
            um_we = 1'b1; um_wa = node_r; um_wd = um_rd | init_bits;
          end
          MODE_SET: if (node_ok) begin
            um_we = 1'b1; um_wa = old_mk; um_wd = um_rd & ~set_bit;
          end
          default: ;
        endcase
      end
      S_W1: begin
        case (mode_r)
          MODE_APPEND: if (clive_r != '0) begin
            nx_we = 1'b1; nx_wa = tail_r; nx_wd = n_r;
          end
          MODE_REMOVE: begin
            nx_we = 1'b1; nx_wa = node_r; nx_wd = fhead_r;
            pv_we = 1'b1; pv_wa = node_r; pv_wd = '0;
            lv_we = 1'b1; lv_wa = node_r; lv_wd = 1'b0;
          end
          MODE_SET: begin
            um_we = 1'b1; um_wa = node_r; um_wd = um_rd | set_bit;
          end
          default: ;
        endcase
      end
      S_TRD: begin
        nx_ra = head_r; um_ra = head_r;
      end
      S_TW: if (um_rd == '0) begin
        nx_we = 1'b1; nx_wa = head_r; nx_wd = fhead_r;
        pv_we = 1'b1; pv_wa = head_r; pv_wd = '0;
        lv_we = 1'b1; lv_wa = head_r; lv_wd = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wcnt_r <= '0; wlim_r <= 11'd1024;
      head_r <= '0; tail_r <= '0; fhead_r <= '0;
      clive_r <= '0; cfree_r <= '0; fresh_r <= '0; trim_r <= '0;
      st_r <= ST_OK; res_r <= '0;
      for (int i = 0; i < MW; i++) marker_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_WORKERS) wcnt_r <= cfg_pwdata[3:0];
        else wlim_r <= cfg_pwdata[10:0];
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          mode_r <= in_mode; node_r <= in_node_index; wid_r <= in_worker_id;
          st_r <= ST_OK; res_r <= '0; trim_r <= '0;
        end
        S_RD1: begin
          case (mode_r)
            MODE_APPEND: begin
              if (app_free) begin
                n_r <= fhead_r; fhead_r <= nx_rd; cfree_r <= cfree_r - CW'(1);
              end else if (app_fresh) begin
                n_r <= fresh_r[NW-1:0]; fresh_r <= fresh_r + CW'(1);
              end else st_r <= ST_ERR;
            end
            MODE_REMOVE: begin
              p_r <= pv_rd; q_r <= nx_rd;
              if (!rm_ok) st_r <= ST_ERR;
            end
            MODE_INIT: begin
              if (!node_ok) st_r <= ST_ERR;
              else for (int i = 0; i < MW; i++) if (init_bits[i]) marker_r[i] <= node_r;
            end
            MODE_SET: if (!node_ok) st_r <= ST_ERR;
            MODE_TRIM: if (clive_r == '0) st_r <= ST_EMPTY;
            MODE_STATUS: ;
            default: st_r <= ST_ERR;
          endcase
        end
        S_W1: begin
          case (mode_r)
            MODE_APPEND: begin
              tail_r <= n_r; res_r <= n_r;
              if (clive_r == '0) head_r <= n_r;
              clive_r <= clive_r + CW'(1);
            end
            MODE_REMOVE: begin
              if (clive_r == CW'(1)) begin
                head_r <= '0; tail_r <= '0;
              end else if (node_r == head_r) head_r <= q_r;
              else if (node_r == tail_r) tail_r <= p_r;
              fhead_r <= node_r;
              cfree_r <= cfree_r + CW'(1); clive_r <= clive_r - CW'(1);
            end
            MODE_SET: marker_r[wid_r] <= node_r;
            default: ;
          endcase
        end
        S_TW: if (um_rd == '0) begin
          if (clive_r == CW'(1)) begin
            head_r <= '0; tail_r <= '0;
          end else head_r <= nx_rd;
          fhead_r <= head_r;
          cfree_r <= cfree_r + CW'(1); clive_r <= clive_r - CW'(1);
          trim_r <= trim_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_status = st_r;
  assign out_result_node = res_r;
  assign out_head_node = (clive_r != '0) ? head_r : '0;
  assign out_tail_node = (clive_r != '0) ? tail_r : '0;
  assign out_live_count = clive_r;
  assign out_free_count = cfree_r;
  assign out_is_full = (clive_r == wlim_r);
  assign out_marker_node = marker_r[wid_r];
  assign out_trimmed = trim_r;
endmodule

// File: design/swnl_ram.sv
`timescale 1ns / 1ps
module swnl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: test/sliding_window_node_list_tb.sv
`timescale 1ns / 1ps
module sliding_window_node_list_tb;
  import swnl_pkg::*;

  localparam logic [2:0] MODE_BAD6 = 3'd6;
  localparam logic [2:0] MODE_BAD7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DIR_ROWS = 21;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  result_node;
    logic [9:0]  head_node;
    logic [9:0]  tail_node;
    logic [10:0] live_count;
    logic [10:0] free_count;
    logic        is_full;
    logic [9:0]  marker_node;
    logic [10:0] trimmed;
    logic        marker_known;
    logic        typed_chk;
    logic [1:0]  typed_status;
  } list_result_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [9:0] node;
    logic [2:0] wid;
    logic       chk;
    logic [1:0] status;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_mode = '0;
  logic [9:0] in_node_index = '0;
  logic [2:0] in_worker_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [9:0] out_result_node, out_head_node, out_tail_node, out_marker_node;
  logic [10:0] out_live_count, out_free_count, out_trimmed;
  logic out_is_full;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  sliding_window_node_list u_dut (.*);

  always #2 clk = ~clk;

  logic [9:0] nxt_link [NODES];
  logic [9:0] prv_link [NODES];
  logic [7:0] node_mask [NODES];
  logic       node_live [NODES];
  logic [9:0] marker_of [MW];
  logic       marker_set [MW];
  int head_p, tail_p, free_p, n_live, n_free, n_fresh;
  int workers_cfg, limit_cfg;

  list_result_t expected_q[$];
  int errors = 0;
  bit quiet = 0;
  int idle_cycles = 0;

  task automatic unlink_node(input int n);
    if (n_live == 1) begin
      head_p = 0;
      tail_p = 0;
    end else if (n == head_p) begin
      head_p = int'(nxt_link[n]);
    end else if (n == tail_p) begin
      tail_p = int'(prv_link[n]);
    end else begin
      nxt_link[prv_link[n]] = nxt_link[n];
      prv_link[nxt_link[n]] = prv_link[n];
    end
    node_live[n] = 0;
    nxt_link[n] = 10'(free_p);
    prv_link[n] = '0;
    free_p = n;
    n_free++;
    n_live--;
  endtask

  task automatic predict_step(input logic [2:0] m, input logic [9:0] nd, input logic [2:0] w,
                              output list_result_t r);
    int n, cnt, i;
    bit ok;
    r = '0;
    ok = nd < n_fresh;
    case (m)
      MODE_APPEND: begin
        n = -1;
        if (n_free > 0) begin
          n = free_p;
          free_p = int'(nxt_link[n]);
          n_free--;
        end else if (n_fresh < NODES) begin
          n = n_fresh;
          n_fresh++;
        end else begin
          r.status = ST_ERR;
        end
        if (n >= 0) begin
          nxt_link[n] = '0;
          node_mask[n] = '0;
          node_live[n] = 1;
          if (n_live == 0) begin
            head_p = n;
            prv_link[n] = '0;
          end else begin
            nxt_link[tail_p] = 10'(n);
            prv_link[n] = 10'(tail_p);
          end
          tail_p = n;
          n_live++;
          r.result_node = 10'(n);
        end
      end
      MODE_REMOVE: begin
        if (ok && node_live[nd]) unlink_node(int'(nd));
        else r.status = ST_ERR;
      end
      MODE_INIT: begin
        if (!ok) begin
          r.status = ST_ERR;
        end else begin
          cnt = workers_cfg > MW ? MW : workers_cfg;
          if (cnt == 0) cnt = 1;
          for (i = 0; i < cnt; i++) begin
            node_mask[nd][i] = 1'b1;
            marker_of[i] = nd;
            marker_set[i] = 1;
          end
        end
      end
      MODE_SET: begin
        if (!ok) begin
          r.status = ST_ERR;
        end else begin
          node_mask[marker_of[w]][w] = 1'b0;
          node_mask[nd][w] = 1'b1;
          marker_of[w] = nd;
          marker_set[w] = 1;
        end
      end
      MODE_TRIM: begin
        if (n_live == 0) begin
          r.status = ST_EMPTY;
        end else begin
          while (n_live > 0 && node_mask[head_p] == 0) begin
            unlink_node(head_p);
            r.trimmed++;
          end
        end
      end
      MODE_STATUS: ;
      default: r.status = ST_ERR;
    endcase
    r.head_node = (n_live != 0) ? 10'(head_p) : '0;
    r.tail_node = (n_live != 0) ? 10'(tail_p) : '0;
    r.live_count = 11'(n_live);
    r.free_count = 11'(n_free);
    r.is_full = (n_live == limit_cfg);
    r.marker_known = marker_set[w];
    r.marker_node = marker_set[w] ? marker_of[w] : '0;
  endtask

  task automatic send_item(input logic [2:0] m, input logic [9:0] nd, input logic [2:0] w,
                           input logic chk, input logic [1:0] st);
    list_result_t r;
    while (!quiet && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_node_index <= nd;
    in_worker_id <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_step(m, nd, w, r);
    r.typed_chk = chk;
    r.typed_status = st;
    expected_q.push_back(r);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == 3'd0) workers_cfg = int'(data[3:0]);
    else limit_cfg = int'(data[10:0]);
    @(posedge clk);
  endtask

  task automatic random_item(input bit fill);
    logic [2:0] m, w;
    logic [9:0] nd;
    int pick, k;
    m = 3'($urandom_range(7));
    nd = 10'($urandom);
    w = 3'($urandom);
    pick = $urandom_range(99);
    if (fill) begin
      if (pick < 90) m = MODE_APPEND;
      else if (pick < 94) m = MODE_REMOVE;
      else m = MODE_STATUS;
    end else if (pick < 30) m = MODE_APPEND;
    else if (pick < 50) m = MODE_REMOVE;
    else if (pick < 58) m = MODE_INIT;
    else if (pick < 73) m = MODE_SET;
    else if (pick < 83) m = MODE_TRIM;
    else if (pick < 90) m = MODE_STATUS;
    if (pick < 90 && n_fresh > 0) begin
      nd = 10'($urandom_range(n_fresh - 1));
      if (m == MODE_REMOVE)
        for (k = 0; k < 8 && !node_live[nd]; k++) nd = 10'($urandom_range(n_fresh - 1));
    end
    if (m == MODE_SET && !marker_set[w]) begin
      m = MODE_STATUS;
      for (k = 0; k < MW; k++)
        if (marker_set[k] && ($urandom_range(1) || m == MODE_STATUS)) begin
          w = 3'(k);
          m = MODE_SET;
        end
    end
    send_item(m, nd, w, 1'b0, ST_OK);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    list_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction on result channel");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); errors++;
        end
        if (e.typed_chk && out_status !== e.typed_status) begin
          $error("status exp %0d got %0d", e.typed_status, out_status); errors++;
        end
        if (out_result_node !== e.result_node) begin
          $error("result_node exp %0d got %0d", e.result_node, out_result_node); errors++;
        end
        if (out_head_node !== e.head_node) begin
          $error("head_node exp %0d got %0d", e.head_node, out_head_node); errors++;
        end
        if (out_tail_node !== e.tail_node) begin
          $error("tail_node exp %0d got %0d", e.tail_node, out_tail_node); errors++;
        end
        if (out_live_count !== e.live_count) begin
          $error("live_count exp %0d got %0d", e.live_count, out_live_count); errors++;
        end
        if (out_free_count !== e.free_count) begin
          $error("free_count exp %0d got %0d", e.free_count, out_free_count); errors++;
        end
        if (out_is_full !== e.is_full) begin
          $error("is_full exp %0d got %0d", e.is_full, out_is_full); errors++;
        end
        if (e.marker_known && out_marker_node !== e.marker_node) begin
          $error("marker_node exp %0d got %0d", e.marker_node, out_marker_node); errors++;
        end
        if (out_trimmed !== e.trimmed) begin
          $error("trimmed exp %0d got %0d", e.trimmed, out_trimmed); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("sliding_window_node_list regression: fail");
      $finish;
    end
  end

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{MODE_STATUS, 10'd0, 3'd0, 1'b1, ST_OK},
    '{MODE_TRIM, 10'd0, 3'd0, 1'b1, ST_EMPTY},
    '{MODE_REMOVE, 10'd0, 3'd0, 1'b1, ST_ERR},
    '{MODE_INIT, 10'd0, 3'd0, 1'b1, ST_ERR},
    '{MODE_APPEND, 10'd0, 3'd0, 1'b1, ST_OK},
    '{MODE_APPEND, 10'd0, 3'd0, 1'b1, ST_OK},
    '{MODE_APPEND, 10'd0, 3'd0, 1'b1, ST_OK},
    '{MODE_INIT, 10'd1, 3'd0, 1'b1, ST_OK},
    '{MODE_SET, 10'd2, 3'd0, 1'b1, ST_OK},
    '{MODE_SET, 10'd2, 3'd0, 1'b1, ST_OK},
    '{MODE_SET, 10'd1023, 3'd0, 1'b1, ST_ERR},
    '{MODE_BAD6, 10'd0, 3'd0, 1'b1, ST_ERR},
    '{MODE_BAD7, 10'd1023, 3'd0, 1'b1, ST_ERR},
    '{MODE_TRIM, 10'd0, 3'd0, 1'b0, ST_OK},
    '{MODE_REMOVE, 10'd2, 3'd0, 1'b1, ST_OK},
    '{MODE_REMOVE, 10'd2, 3'd0, 1'b1, ST_ERR},
    '{MODE_TRIM, 10'd0, 3'd0, 1'b1, ST_EMPTY},
    '{MODE_APPEND, 10'd0, 3'd0, 1'b1, ST_OK},
    '{MODE_STATUS, 10'd1023, 3'd7, 1'b1, ST_OK},
    '{MODE_REMOVE, 10'd1023, 3'd7, 1'b1, ST_ERR},
    '{MODE_INIT, 10'd0, 3'd7, 1'b0, ST_OK}
  };

  initial begin
    int i, extra;
    for (i = 0; i < NODES; i++) begin
      node_live[i] = 0;
      node_mask[i] = 0;
      nxt_link[i] = 0;
      prv_link[i] = 0;
    end
    for (i = 0; i < MW; i++) begin
      marker_of[i] = 0;
      marker_set[i] = 0;
    end
    head_p = 0; tail_p = 0; free_p = 0;
    n_live = 0; n_free = 0; n_fresh = 0;
    workers_cfg = 0; limit_cfg = 1024;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++)
      send_item(dir_rows[i].mode, dir_rows[i].node, dir_rows[i].wid,
                dir_rows[i].chk, dir_rows[i].status);

    cfg_write(3'd0, 32'd8);
    cfg_write(3'd4, 32'd0);
    for (i = 0; i < 150; i++) begin
      quiet = i >= 70 && i < 130;
      random_item(1'b0);
    end
    quiet = 0;

    cfg_write(3'd0, 32'd15);
    cfg_write(3'd4, 32'd1024);
    extra = 0;
    while (extra < 15) begin
      random_item(1'b1);
      if (n_fresh == NODES && n_free == 0) extra++;
    end

    cfg_write(3'd0, 32'd3);
    cfg_write(3'd4, $urandom_range(2047));
    for (i = 0; i < 100; i++) random_item(1'b0);
    cfg_write(3'd0, 32'd0);
    cfg_write(3'd4, 32'd5);
    for (i = 0; i < 60; i++) random_item(1'b0);
    send_item(MODE_TRIM, 10'd0, 3'd0, 1'b0, ST_OK);

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("sliding_window_node_list regression: pass");
    end else begin
      $display("sliding_window_node_list regression: fail");
    end
    $finish;
  end

endmodule

// File: sliding_window_node_list.f
design/swnl_pkg.sv
design/swnl_ram.sv
design/sliding_window_node_list.sv
test/sliding_window_node_list_tb.sv
